/* sv/mru_pkg.sv */
// Package for the bounded MRU id list: payload structs, operation codes,
// register indexes and sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mru_pkg;

	localparam int CAPACITY  = 16;
	localparam int NUM_LISTS = 2;

	localparam int ID_W    = 32;
	localparam int SEL_W   = 1;
	localparam int LIMIT_W = 5;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int DEPTH   = NUM_LISTS * CAPACITY;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	// register index = byte address / 4
	localparam logic REG_LIMIT  = 1'b0;
	localparam logic REG_UNIQUE = 1'b1;

	typedef struct packed {
		func_t             func;
		logic [SEL_W-1:0]  list_select;
		logic [ID_W-1:0]   entry_id;
		logic              name_present;
	} cmd_t;

	typedef struct packed {
		logic              accepted;
		logic              found;
		logic [CNT_W-1:0]  entry_count;
		logic              evicted;
	} rsp_t;

endpackage

`default_nettype wire

/* sv/bounded_mru_id_list_core.sv */
// Bounded MRU id list core: list ids in one synchronous RAM, scan/compact and shift.
// A named add scans the list, drops the oldest entry when at the limit, then shifts
// the list to put the new id at the front; others only scan. The next word is
// accepted the cycle after the response loads.
// Reset clears list lengths, control and output valid; entry_limit=16, unique=1.
// Depends on mru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bounded_mru_id_list_core
	import mru_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// command channel
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire cmd_t               cmd,
	// response channel
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_t                    rsp,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POST,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	localparam logic [CNT_W-1:0]  CAP_C = CNT_W'(CAPACITY);
	localparam logic [ADDR_W-1:0] CAP_A = ADDR_W'(CAPACITY);

	// configuration registers
	logic [LIMIT_W-1:0] entry_limit_q;
	logic               unique_q;

	// control and working registers
	state_t             state_q;
	func_t              func_q;
	logic [SEL_W-1:0]   sel_q;
	logic [ID_W-1:0]    id_q;
	logic               named_q;
	logic               purge_q;
	logic [CNT_W-1:0]   len_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   w_q;
	logic               rd_vld_q;
	logic               found_q;
	logic               evicted_q;
	logic [CNT_W-1:0]   list_length_q [NUM_LISTS];
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// entry RAM
	logic [ID_W-1:0]    mem [DEPTH];
	logic [ID_W-1:0]    mem_rdata_q;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ID_W-1:0]    mem_wdata;
	logic               mem_we;

	logic [ADDR_W-1:0]  base;
	logic [CNT_W-1:0]   lim;
	logic               issue;
	logic               id_match;
	logic               cmd_take;
	logic               rsp_load;
	logic               cfg_wr;

	//--------------------------------------------------------------------
	// Configuration port: zero wait states, written on the access phase.
	//--------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_limit_q <= LIMIT_RESET;
			unique_q      <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_LIMIT:  entry_limit_q <= pwdata[LIMIT_W-1:0];
				REG_UNIQUE: unique_q      <= pwdata[0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LIMIT:  prdata = PDATA_W'(entry_limit_q);
			REG_UNIQUE: prdata = PDATA_W'(unique_q);
			default:    prdata = '0;
		endcase
	end

	// Zero or anything beyond the physical size means full capacity.
	assign lim = (entry_limit_q == '0 || int'(entry_limit_q) > CAPACITY)
		? CAP_C : CNT_W'(entry_limit_q);

	//--------------------------------------------------------------------
	// Handshakes. A new word enters only from idle; the response register
	// decouples the output so a pending response does not block the next.
	//--------------------------------------------------------------------
	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign rsp_load  = (state_q == ST_FINISH) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// List L lives at slots L*CAPACITY upward, front (newest) first.
	assign base = ADDR_W'(sel_q) * CAP_A;

	// Scan walks up from the front; shift walks down from the tail.
	always_comb begin
		issue     = 1'b0;
		mem_raddr = base + ADDR_W'(idx_q);
		case (state_q)
			ST_SCAN:  issue = (idx_q < len_q);
			ST_SHIFT: begin
				issue     = (idx_q != '0);
				mem_raddr = base + ADDR_W'(idx_q - CNT_W'(1));
			end
			default:  issue = 1'b0;
		endcase
	end

	assign id_match = (mem_rdata_q == id_q);

	// One write per cycle. Scan writes kept ids down to the compaction
	// point, which never passes the read point. Shift writes each id one
	// slot toward the tail, then drops the new id at the front.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = base + ADDR_W'(w_q);
		mem_wdata = mem_rdata_q;
		case (state_q)
			ST_SCAN:  mem_we = rd_vld_q && purge_q && !id_match;
			ST_SHIFT: begin
				if (rd_vld_q) begin
					mem_we = 1'b1;
				end else if (idx_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = base;
					mem_wdata = id_q;
				end
			end
			default:  mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	//--------------------------------------------------------------------
	// Sequencer: scan (presence + optional compaction), post (eviction),
	// shift (make room at the front), finish (publish the response).
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			func_q      <= FUNC_ADD;
			sel_q       <= '0;
			id_q        <= '0;
			named_q     <= 1'b0;
			purge_q     <= 1'b0;
			len_q       <= '0;
			idx_q       <= '0;
			w_q         <= '0;
			rd_vld_q    <= 1'b0;
			found_q     <= 1'b0;
			evicted_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				list_length_q[i] <= '0;
			end
		end else begin
			rd_vld_q <= issue;
			// drop the sent response unless a new one loads this cycle
			if (rsp_valid_q && !rsp_stall && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						func_q    <= cmd.func;
						sel_q     <= cmd.list_select;
						id_q      <= cmd.entry_id;
						named_q   <= cmd.name_present;
						purge_q   <= (cmd.func == FUNC_REMOVE) ||
							(cmd.func == FUNC_ADD && cmd.name_present && unique_q);
						len_q     <= list_length_q[cmd.list_select];
						idx_q     <= '0;
						w_q       <= '0;
						found_q   <= 1'b0;
						evicted_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end

				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (rd_vld_q && id_match) begin
						found_q <= 1'b1;
					end
					if (mem_we) begin
						w_q <= w_q + CNT_W'(1);
					end
					if (!issue && !rd_vld_q) begin
						if (purge_q) begin
							len_q <= w_q;
						end
						state_q <= ST_POST;
					end
				end

				ST_POST: begin
					if (func_q == FUNC_ADD && named_q) begin
						// drop the oldest entry when still at the limit
						if (len_q >= lim) begin
							len_q     <= len_q - CNT_W'(1);
							idx_q     <= len_q - CNT_W'(1);
							evicted_q <= 1'b1;
						end else begin
							idx_q <= len_q;
						end
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_FINISH;
					end
				end

				ST_SHIFT: begin
					if (issue) begin
						w_q   <= idx_q;
						idx_q <= idx_q - CNT_W'(1);
					end
					if (!issue && !rd_vld_q) begin
						len_q   <= len_q + CNT_W'(1);
						state_q <= ST_FINISH;
					end
				end

				ST_FINISH: begin
					if (rsp_load) begin
						rsp_valid_q          <= 1'b1;
						rsp_q.accepted       <= (func_q != FUNC_ADD) || named_q;
						rsp_q.found          <= found_q;
						rsp_q.entry_count    <= (func_q == FUNC_CLEAR) ? '0 : len_q;
						rsp_q.evicted        <= evicted_q;
						if (func_q == FUNC_CLEAR) begin
							for (int i = 0; i < NUM_LISTS; i++) begin
								list_length_q[i] <= '0;
							end
						end else begin
							list_length_q[sel_q] <= len_q;
						end
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	//--------------------------------------------------------------------
	// Checks
	//--------------------------------------------------------------------
	// compaction point never overtakes the read point
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (w_q <= idx_q))
		else $error("compaction write index passed read index");

	// RAM is only written while an operation walks a list
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SCAN || state_q == ST_SHIFT))
		else $error("entry RAM written outside scan or shift");

	// an eviction only comes with an accepted add and leaves a non-empty list
	a_evict_add: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.evicted) |-> (rsp.accepted && rsp.entry_count != '0))
		else $error("eviction reported without an accepted add");

	// a clear leaves every list empty
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && func_q == FUNC_CLEAR) |=>
			(list_length_q[0] == '0 && list_length_q[NUM_LISTS-1] == '0))
		else $error("clear left a list non-empty");

	// stored lengths stay within the physical size
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(list_length_q[sel_q] <= CAP_C) && (len_q <= CAP_C))
		else $error("list length beyond capacity");

endmodule

`default_nettype wire
